FILE: hdl/rbsi_pkg.sv
// rbsi_pkg: shared types and constants for the ray versus box slab test core
// holds the request/result payload structs and the divider handshake structs
// no dependencies
package rbsi_pkg;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Z    = 3'd5;

   // saturation limits of a signed 32-bit slab distance
   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   // one vertex request
   typedef struct packed {
      logic signed [31:0] vertex_x;
      logic signed [31:0] vertex_y;
      logic signed [31:0] vertex_z;
      logic               is_last;
   } rbsi_req_type;

   // one test result
   typedef struct packed {
      logic        hit;
      logic [30:0] distance;
   } rbsi_rsp_type;

   // divider launch: t = (bound - org) * 2^FRAC_BITS / dir
   typedef struct packed {
      logic               start;
      logic signed [31:0] bound;
      logic signed [31:0] org;
      logic signed [31:0] dir;
   } rbsi_div_req_type;

   // divider completion, saturated quotient
   typedef struct packed {
      logic               done;
      logic signed [31:0] quotient;
   } rbsi_div_rsp_type;

endpackage

FILE: hdl/rbsi_divider.sv
// rbsi_divider: bit-serial signed fixed-point divider for slab distances
// truncates toward zero and saturates to signed 32 bits, one quotient bit a cycle
// depends on rbsi_pkg
module rbsi_divider #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rbsi_pkg::rbsi_div_req_type div_req,
   output rbsi_pkg::rbsi_div_rsp_type div_rsp
);
   import rbsi_pkg::*;

   // numerator magnitude: 33-bit difference shifted by the fraction bits
   localparam int NUM_W = 33 + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);
   localparam logic [NUM_W-1:0] LIM_NEG = NUM_W'(64'h8000_0000);
   localparam logic [NUM_W-1:0] LIM_POS = NUM_W'(64'h7FFF_FFFF);

   localparam logic [1:0] D_IDLE = 2'd0;
   localparam logic [1:0] D_PREP = 2'd1;
   localparam logic [1:0] D_RUN  = 2'd2;
   localparam logic [1:0] D_FIX  = 2'd3;

   logic [1:0]         dstate_ff, dstate_in;
   logic signed [32:0] diff_ff, diff_in;
   logic signed [31:0] dir_ff, dir_in;
   logic               neg_ff, neg_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [31:0]        den_ff, den_in;
   logic [31:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic signed [31:0] quot_ff, quot_in;

   logic [32:0] trial;
   logic [32:0] diff_mag;
   logic        qbit;

   // next state of the divider
   always_comb begin
      dstate_in = dstate_ff;
      diff_in   = diff_ff;
      dir_in    = dir_ff;
      neg_in    = neg_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      quot_in   = quot_ff;
      trial     = {rem_ff, num_ff[NUM_W-1]};
      qbit      = (trial >= {1'b0, den_ff});
      diff_mag  = diff_ff[32] ? 33'(-diff_ff) : 33'(diff_ff);
      case (dstate_ff)
         D_IDLE: begin
            if (div_req.start) begin
               diff_in   = 33'({div_req.bound[31], div_req.bound})
                         - 33'({div_req.org[31], div_req.org});
               dir_in    = div_req.dir;
               dstate_in = D_PREP;
            end
         end
         // take magnitudes and signs
         D_PREP: begin
            neg_in    = diff_ff[32] ^ dir_ff[31];
            num_in    = {diff_mag, {FRAC_BITS{1'b0}}};
            den_in    = dir_ff[31] ? 32'(-dir_ff) : 32'(dir_ff);
            rem_in    = '0;
            cnt_in    = '0;
            dstate_in = D_RUN;
         end
         // restoring step, quotient bits shift in behind the numerator
         D_RUN: begin
            rem_in = qbit ? 32'(trial - {1'b0, den_ff}) : trial[31:0];
            num_in = {num_ff[NUM_W-2:0], qbit};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               dstate_in = D_FIX;
            end
         end
         // apply sign and saturate
         D_FIX: begin
            if (neg_ff) begin
               quot_in = (num_ff > LIM_NEG) ? S32_MIN : 32'(-num_ff[31:0]);
            end else begin
               quot_in = (num_ff > LIM_POS) ? S32_MAX : num_ff[31:0];
            end
            done_in   = 1'b1;
            dstate_in = D_IDLE;
         end
         default: begin
            dstate_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dstate_ff <= D_IDLE;
         done_ff   <= 1'b0;
      end else begin
         dstate_ff <= dstate_in;
         done_ff   <= done_in;
      end
      diff_ff <= diff_in;
      dir_ff  <= dir_in;
      neg_ff  <= neg_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

FILE: hdl/ray_box_slab_intersect_core.sv
// ray_box_slab_intersect_core: running bounding box of a vertex stream and
// a slab test of the configured ray against it on the last vertex
// depends on rbsi_pkg and rbsi_divider
//
//   channel  direction  ports                              moves
//   req      in         req_valid req_ready req_payload     one vertex
//   rsp      out        rsp_valid rsp_ready rsp_payload     hit flag and distance
//   csr      in         csr_valid csr_ready csr_index csr_data  ray origin/direction
//
// a vertex without is_last grows the box, leaves req_ready high and gives no result
// a last vertex runs two serial divisions per axis with a nonzero direction
// on one shared bit-serial divider; req_ready is low until the test is done
// the result sits in an output register; a pending result stalls only the next test
// reset is synchronous and needs no clearing pass; csr writes are always taken
module ray_box_slab_intersect_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  rbsi_pkg::rbsi_req_type             req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output rbsi_pkg::rbsi_rsp_type             rsp_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rbsi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                        csr_data
);
   import rbsi_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_AXIS   = 3'd1;
   localparam logic [2:0] ST_DIV_LO = 3'd2;
   localparam logic [2:0] ST_DIV_HI = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic signed [31:0] ONE_FIXED = 32'sd1 <<< FRAC_BITS;

   // ray registers
   logic signed [31:0] org_x_ff, org_y_ff, org_z_ff;
   logic signed [31:0] dir_x_ff, dir_y_ff, dir_z_ff;

   // running box, loaded by the first vertex of each mesh
   logic signed [31:0] min_x_ff, min_y_ff, min_z_ff, max_x_ff, max_y_ff, max_z_ff;
   logic signed [31:0] min_x_in, min_y_in, min_z_in, max_x_in, max_y_in, max_z_in;
   logic               first_ff, first_in;

   // sequencer
   logic [2:0]         state_ff, state_in;
   logic [1:0]         axis_ff, axis_in;
   logic               miss_ff, miss_in;
   logic signed [31:0] near_ff, near_in, far_ff, far_in;
   logic signed [31:0] slab_a_ff, slab_a_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   rbsi_rsp_type       rsp_ff, rsp_in;

   rbsi_div_req_type   div_req;
   rbsi_div_rsp_type   div_rsp;

   logic               req_fire;
   logic signed [31:0] sel_lo, sel_hi, sel_org, sel_dir;
   logic signed [31:0] t_small, t_big;
   logic               out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // per-axis operand select
   always_comb begin
      case (axis_ff)
         AXIS_X: begin
            sel_lo = min_x_ff; sel_hi = max_x_ff; sel_org = org_x_ff; sel_dir = dir_x_ff;
         end
         AXIS_Y: begin
            sel_lo = min_y_ff; sel_hi = max_y_ff; sel_org = org_y_ff; sel_dir = dir_y_ff;
         end
         default: begin
            sel_lo = min_z_ff; sel_hi = max_z_ff; sel_org = org_z_ff; sel_dir = dir_z_ff;
         end
      endcase
   end

   // divider launch: low bound from the axis step, high bound once the low one is back
   always_comb begin
      div_req.start = ((state_ff == ST_AXIS) && (sel_dir != 32'sd0))
                   || ((state_ff == ST_DIV_LO) && div_rsp.done);
      div_req.bound = (state_ff == ST_DIV_LO) ? sel_hi : sel_lo;
      div_req.org   = sel_org;
      div_req.dir   = sel_dir;
   end

   rbsi_divider #(
      .FRAC_BITS (FRAC_BITS)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // order the two slab distances
   always_comb begin
      if (slab_a_ff > div_rsp.quotient) begin
         t_small = div_rsp.quotient;
         t_big   = slab_a_ff;
      end else begin
         t_small = slab_a_ff;
         t_big   = div_rsp.quotient;
      end
   end

   // box growth on each accepted vertex
   always_comb begin
      min_x_in = min_x_ff; min_y_in = min_y_ff; min_z_in = min_z_ff;
      max_x_in = max_x_ff; max_y_in = max_y_ff; max_z_in = max_z_ff;
      first_in = first_ff;
      if (req_fire) begin
         if (first_ff) begin
            min_x_in = req_payload.vertex_x; max_x_in = req_payload.vertex_x;
            min_y_in = req_payload.vertex_y; max_y_in = req_payload.vertex_y;
            min_z_in = req_payload.vertex_z; max_z_in = req_payload.vertex_z;
         end else begin
            if (req_payload.vertex_x < min_x_ff) min_x_in = req_payload.vertex_x;
            if (req_payload.vertex_y < min_y_ff) min_y_in = req_payload.vertex_y;
            if (req_payload.vertex_z < min_z_ff) min_z_in = req_payload.vertex_z;
            if (req_payload.vertex_x > max_x_ff) max_x_in = req_payload.vertex_x;
            if (req_payload.vertex_y > max_y_ff) max_y_in = req_payload.vertex_y;
            if (req_payload.vertex_z > max_z_ff) max_z_in = req_payload.vertex_z;
         end
         first_in = req_payload.is_last;
      end
   end

   // slab test sequencer
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      miss_in      = miss_ff;
      near_in      = near_ff;
      far_in       = far_ff;
      slab_a_in    = slab_a_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_payload.is_last) begin
               axis_in  = AXIS_X;
               miss_in  = 1'b0;
               near_in  = S32_MIN;
               far_in   = S32_MAX;
               state_in = ST_AXIS;
            end
         end
         // nonzero direction launches the divider; zero direction: unbounded slab or an outright miss
         ST_AXIS: begin
            if (sel_dir != 32'sd0) begin
               state_in = ST_DIV_LO;
            end else if ((sel_org < sel_lo) || (sel_org > sel_hi)) begin
               miss_in  = 1'b1;
               state_in = ST_FINISH;
            end else if (axis_ff == AXIS_Z) begin
               state_in = ST_FINISH;
            end else begin
               axis_in = axis_ff + 1'b1;
            end
         end
         ST_DIV_LO: begin
            if (div_rsp.done) begin
               slab_a_in = div_rsp.quotient;
               state_in  = ST_DIV_HI;
            end
         end
         // narrow near and far by this axis
         ST_DIV_HI: begin
            if (div_rsp.done) begin
               if (t_small > near_ff) near_in = t_small;
               if (t_big < far_ff)    far_in  = t_big;
               if (axis_ff == AXIS_Z) begin
                  state_in = ST_FINISH;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = ST_AXIS;
               end
            end
         end
         // decide and load the output register once it is free
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (miss_ff || (far_ff < 32'sd0) || (near_ff > far_ff)) begin
                  rsp_in.hit      = 1'b0;
                  rsp_in.distance = '0;
               end else begin
                  rsp_in.hit      = 1'b1;
                  rsp_in.distance = (near_ff < 32'sd0) ? far_ff[30:0] : near_ff[30:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff <= '0;
         org_y_ff <= '0;
         org_z_ff <= '0;
         dir_x_ff <= '0;
         dir_y_ff <= '0;
         dir_z_ff <= ONE_FIXED;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ORIGIN_X: org_x_ff <= csr_data;
            CSR_ORIGIN_Y: org_y_ff <= csr_data;
            CSR_ORIGIN_Z: org_z_ff <= csr_data;
            CSR_DIR_X:    dir_x_ff <= csr_data;
            CSR_DIR_Y:    dir_y_ff <= csr_data;
            CSR_DIR_Z:    dir_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // control and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      axis_ff   <= axis_in;
      miss_ff   <= miss_in;
      near_ff   <= near_in;
      far_ff    <= far_in;
      slab_a_ff <= slab_a_in;
      rsp_ff    <= rsp_in;
      min_x_ff  <= min_x_in;
      min_y_ff  <= min_y_in;
      min_z_ff  <= min_z_in;
      max_x_ff  <= max_x_in;
      max_y_ff  <= max_y_in;
      max_z_ff  <= max_z_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
